FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge once reset is released.
`define QR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define QR_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/qrsc_pkg.sv
`default_nettype none

package qrsc_pkg;

	// fixed field widths
	localparam int IDX_FIELD_W = 20;
	localparam int COORD_W     = 5;
	localparam int BOUND_W     = 32;
	localparam int SC_W        = 21;
	localparam int CFG_INDEX_W = 2;

	// input beat layout, lowest bit first
	localparam int IDX_LSB     = 0;
	localparam int COORD_LSB   = IDX_LSB + IDX_FIELD_W;
	localparam int LOWER_LSB   = COORD_LSB + COORD_W;
	localparam int UPPER_LSB   = LOWER_LSB + BOUND_W;
	localparam int IN_FIELDS_W = UPPER_LSB + BOUND_W;
	localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_MODE     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIMENSION_COUNT = 2'd2;

	// sampling modes
	localparam logic MODE_HALTON     = 1'b0;
	localparam logic MODE_HAMMERSLEY = 1'b1;

	localparam int MAX_DIMENSIONS = 30;
	localparam int FRAC_W         = 32;
	localparam int STEP_W         = $clog2(FRAC_W);
	localparam int DIGIT_W        = 8;
	localparam int RECIP_W        = 32;
	localparam int MUL_W          = 32;
	localparam int PROD_W         = 2 * MUL_W;

	localparam int PRIME_COUNT = 40;
	localparam int PRIME_IDX_W = $clog2(PRIME_COUNT);

	typedef logic [DIGIT_W-1:0] prime_t;
	typedef logic [RECIP_W-1:0] recip_t;

	localparam prime_t PRIMES [PRIME_COUNT] = '{
		8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,
		8'd23,  8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,
		8'd59,  8'd61,  8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,
		8'd97,  8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131,
		8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173
	};

	// ceil(2^32 / p): exact quotient for any dividend below 2^20
	localparam logic [63:0] RECIP_TOP = 64'hFFFF_FFFF;

	localparam recip_t RECIPS [PRIME_COUNT] = '{
		32'(RECIP_TOP / 2 + 1),   32'(RECIP_TOP / 3 + 1),
		32'(RECIP_TOP / 5 + 1),   32'(RECIP_TOP / 7 + 1),
		32'(RECIP_TOP / 11 + 1),  32'(RECIP_TOP / 13 + 1),
		32'(RECIP_TOP / 17 + 1),  32'(RECIP_TOP / 19 + 1),
		32'(RECIP_TOP / 23 + 1),  32'(RECIP_TOP / 29 + 1),
		32'(RECIP_TOP / 31 + 1),  32'(RECIP_TOP / 37 + 1),
		32'(RECIP_TOP / 41 + 1),  32'(RECIP_TOP / 43 + 1),
		32'(RECIP_TOP / 47 + 1),  32'(RECIP_TOP / 53 + 1),
		32'(RECIP_TOP / 59 + 1),  32'(RECIP_TOP / 61 + 1),
		32'(RECIP_TOP / 67 + 1),  32'(RECIP_TOP / 71 + 1),
		32'(RECIP_TOP / 73 + 1),  32'(RECIP_TOP / 79 + 1),
		32'(RECIP_TOP / 83 + 1),  32'(RECIP_TOP / 89 + 1),
		32'(RECIP_TOP / 97 + 1),  32'(RECIP_TOP / 101 + 1),
		32'(RECIP_TOP / 103 + 1), 32'(RECIP_TOP / 107 + 1),
		32'(RECIP_TOP / 109 + 1), 32'(RECIP_TOP / 113 + 1),
		32'(RECIP_TOP / 127 + 1), 32'(RECIP_TOP / 131 + 1),
		32'(RECIP_TOP / 137 + 1), 32'(RECIP_TOP / 139 + 1),
		32'(RECIP_TOP / 149 + 1), 32'(RECIP_TOP / 151 + 1),
		32'(RECIP_TOP / 157 + 1), 32'(RECIP_TOP / 163 + 1),
		32'(RECIP_TOP / 167 + 1), 32'(RECIP_TOP / 173 + 1)
	};

endpackage

`default_nettype wire

FILE: hdl/quasi_random_sample_coordinate_top.sv
`default_nettype none
`include "assert_macros.svh"

// Quasi-random sample coordinate generator (Halton / Hammersley). Each input
// beat asks for coordinate j of sample i and returns one output beat holding
// that coordinate scaled into [lower_bound, upper_bound] (signed Q16.16,
// saturated). Halton mode uses the radical inverse of i in prime j+1 (2, 3,
// 5, ...); Hammersley mode gives coordinate 0 as i / sample_count (held just
// below one when i >= sample_count or the count is zero) and coordinate j as
// the radical inverse in prime j. Fractions are 32-bit, truncated. A
// coordinate at or above dimension_count (or 30) returns zero with
// out_of_range set. One item is in flight at a time; s_axis_tready is high
// only while the sequencer is idle, and a finished result waits in the output
// register without stopping the next input beat. The sequencer runs its steps
// over one shared 32x32 multiplier and one compare/subtract unit: accept,
// then per base-p digit of sample_index a reciprocal multiply and a digit
// accumulate, then restoring division for the fraction, then scaling and the
// output register. Hammersley coordinate 0 skips the digit steps (and the
// division when held just below one); an out-of-range request goes straight
// to the output register. A result held up by m_axis_tready stalls the
// sequencer in its final step until the output register is free.
// Configuration writes are taken every cycle and belong to idle periods.
module quasi_random_sample_coordinate_top import qrsc_pkg::*; #(
	parameter int INDEX_BITS = 20
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration write channel
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [SC_W-1:0]        cfg_data,
	// request stream
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: sample_index[19:0], coordinate[24:20], lower_bound[56:25],
	//        upper_bound[88:57], zero pad[95:89]
	input  wire [S_TDATA_W-1:0]   s_axis_tdata,
	// result stream
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// tdata: coordinate_value[31:0]
	output logic [BOUND_W-1:0]    m_axis_tdata,
	// tuser: out_of_range[0]
	output logic                  m_axis_tuser
);

	// only the low INDEX_BITS of the index field take part
	localparam int IDX_W = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
	// rev and den stay below p * 2^IDX_W; also hold sample_count
	localparam int DEN_W = (IDX_W + DIGIT_W > SC_W) ? IDX_W + DIGIT_W : SC_W;
	localparam int QB_W  = IDX_W + DIGIT_W;

	typedef logic [2:0] state_t;
	localparam state_t ST_IDLE      = 3'd0;
	localparam state_t ST_DIGIT_MUL = 3'd1;
	localparam state_t ST_DIGIT_ACC = 3'd2;
	localparam state_t ST_DIVIDE    = 3'd3;
	localparam state_t ST_SCALE_MUL = 3'd4;
	localparam state_t ST_SCALE_FIN = 3'd5;

	// control
	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                m_valid_q;
	logic                mode_q;
	logic [SC_W-1:0]     count_q;
	logic [COORD_W-1:0]  dim_q;

	// datapath
	logic [IDX_W-1:0]    k_q;
	prime_t              base_q;
	recip_t              recip_q;
	logic [DEN_W-1:0]    rev_q;
	logic [DEN_W-1:0]    den_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [MUL_W-1:0]    mag_q;
	logic                neg_q;
	logic [BOUND_W-1:0]  lower_q;
	logic                oor_q;
	logic [PROD_W-1:0]   prod_q;
	logic [BOUND_W-1:0]  m_data_q;
	logic                m_user_q;

	// request fields
	logic [IDX_W-1:0]       in_idx;
	logic [COORD_W-1:0]     in_coord;
	logic [BOUND_W-1:0]     in_lower;
	logic [BOUND_W-1:0]     in_upper;
	logic                   in_accept;
	logic                   in_oor;
	logic                   ham_first;
	logic                   ham_sat;
	logic [PRIME_IDX_W-1:0] pidx;
	prime_t                 in_base;
	recip_t                 in_recip;
	logic [BOUND_W:0]       span;
	logic [BOUND_W:0]       span_neg;

	// shared units
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [DEN_W:0]      div_shift;
	logic [DEN_W:0]      div_diff;
	logic                div_take;

	// digit step
	logic [IDX_W-1:0]    kq;
	logic [QB_W-1:0]     qb;
	prime_t              digit;

	// scaling
	logic [BOUND_W-1:0]  sc_q;
	logic                sc_rest;
	logic [BOUND_W+1:0]  sc_s;
	logic [BOUND_W+1:0]  sc_v;
	logic [BOUND_W-1:0]  sc_sat;
	logic                out_free;

	assign in_idx   = s_axis_tdata[IDX_LSB +: IDX_W];
	assign in_coord = s_axis_tdata[COORD_LSB +: COORD_W];
	assign in_lower = s_axis_tdata[LOWER_LSB +: BOUND_W];
	assign in_upper = s_axis_tdata[UPPER_LSB +: BOUND_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign in_oor    = (in_coord >= dim_q) || (int'(in_coord) >= MAX_DIMENSIONS);
	assign ham_first = (mode_q == MODE_HAMMERSLEY) && (in_coord == '0);
	assign ham_sat   = (count_q == '0) || (SC_W'(in_idx) >= count_q);

	// Hammersley shifts the prime list by one coordinate
	assign pidx = PRIME_IDX_W'(in_coord)
		- PRIME_IDX_W'((mode_q == MODE_HAMMERSLEY) && (in_coord != '0));
	assign in_base  = (pidx < PRIME_IDX_W'(PRIME_COUNT)) ? PRIMES[pidx] : PRIMES[0];
	assign in_recip = (pidx < PRIME_IDX_W'(PRIME_COUNT)) ? RECIPS[pidx] : RECIPS[0];

	// span magnitude and sign, 33-bit exact
	assign span     = {in_upper[BOUND_W-1], in_upper} - {in_lower[BOUND_W-1], in_lower};
	assign span_neg = ~span + 1'b1;

	// shared multiplier: reciprocal divide of k, or span * fraction
	assign mul_a = (state_q == ST_DIGIT_MUL) ? MUL_W'(k_q) : mag_q;
	assign mul_b = (state_q == ST_DIGIT_MUL) ? recip_q : frac_q;

	// shared compare/subtract: one restoring division step
	assign div_shift = {rev_q, 1'b0};
	assign div_diff  = div_shift - {1'b0, den_q};
	assign div_take  = !div_diff[DEN_W];

	// k / p from the registered product, k % p by back-multiplication
	assign kq    = prod_q[MUL_W +: IDX_W];
	assign qb    = QB_W'(kq) * QB_W'(base_q);
	assign digit = DIGIT_W'(QB_W'(k_q) - qb);

	// lower + floor(frac * span / 2^32), floor toward minus infinity
	assign sc_q    = prod_q[PROD_W-1 -: BOUND_W];
	assign sc_rest = |prod_q[FRAC_W-1:0];
	assign sc_s    = neg_q ? ((BOUND_W+2)'(0) - (BOUND_W+2)'(sc_q) - (BOUND_W+2)'(sc_rest))
	                       : (BOUND_W+2)'(sc_q);
	assign sc_v    = {{2{lower_q[BOUND_W-1]}}, lower_q} + sc_s;

	always_comb begin
		if (sc_v[BOUND_W+1:BOUND_W-1] == 3'b000 || sc_v[BOUND_W+1:BOUND_W-1] == 3'b111) begin
			sc_sat = sc_v[BOUND_W-1:0];
		end else if (sc_v[BOUND_W+1]) begin
			sc_sat = {1'b1, {(BOUND_W-1){1'b0}}};
		end else begin
			sc_sat = {1'b0, {(BOUND_W-1){1'b1}}};
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HAMMERSLEY;
			count_q <= SC_W'(1024);
			dim_q   <= COORD_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SAMPLE_MODE:     mode_q  <= cfg_data[0];
				CFG_SAMPLE_COUNT:    count_q <= cfg_data;
				CFG_DIMENSION_COUNT: dim_q   <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SCALE_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_accept) begin
						if (in_oor) begin
							state_q <= ST_SCALE_FIN;
						end else if (ham_first) begin
							state_q <= ham_sat ? ST_SCALE_MUL : ST_DIVIDE;
						end else begin
							state_q <= (in_idx == '0) ? ST_DIVIDE : ST_DIGIT_MUL;
						end
					end
				end
				ST_DIGIT_MUL: state_q <= ST_DIGIT_ACC;
				ST_DIGIT_ACC: state_q <= (kq == '0) ? ST_DIVIDE : ST_DIGIT_MUL;
				ST_DIVIDE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(FRAC_W - 1)) begin
						state_q <= ST_SCALE_MUL;
					end
				end
				ST_SCALE_MUL: state_q <= ST_SCALE_FIN;
				ST_SCALE_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					k_q     <= in_idx;
					base_q  <= in_base;
					recip_q <= in_recip;
					lower_q <= in_lower;
					neg_q   <= span[BOUND_W];
					mag_q   <= span[BOUND_W] ? span_neg[BOUND_W-1:0] : span[BOUND_W-1:0];
					oor_q   <= in_oor;
					// held just below one when the index reaches the count or the count is zero
					frac_q  <= (ham_first && ham_sat) ? '1 : '0;
					if (ham_first) begin
						rev_q <= DEN_W'(in_idx);
						den_q <= DEN_W'(count_q);
					end else begin
						rev_q <= '0;
						den_q <= DEN_W'(1);
					end
				end
			end
			ST_DIGIT_ACC: begin
				k_q   <= kq;
				rev_q <= DEN_W'(rev_q * DEN_W'(base_q)) + DEN_W'(digit);
				den_q <= DEN_W'(den_q * DEN_W'(base_q));
			end
			ST_DIVIDE: begin
				rev_q  <= div_take ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], div_take};
			end
			ST_SCALE_FIN: begin
				if (out_free) begin
					m_data_q <= oor_q ? '0 : sc_sat;
					m_user_q <= oor_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`QR_ASSERT(a_div_den_nonzero, (state_q == ST_DIVIDE) |-> (den_q != '0),
		"division entered with zero divisor")
	`QR_ASSERT(a_div_rem_below, (state_q == ST_DIVIDE) |-> (rev_q < den_q),
		"division remainder not below divisor")
	`QR_ASSERT(a_digit_k_nonzero, (state_q == ST_DIGIT_ACC) |-> (k_q != '0),
		"digit step on an exhausted index")
	`QR_ASSERT_NEXT(a_accept_busy, in_accept, (state_q != ST_IDLE),
		"accepted request left the sequencer idle")

endmodule

`default_nettype wire
